@@ src/gpio_port_controller_with_irq_top_macros.svh @@
// assertion macros used by the checker file gpio_chk.sv
`ifndef GPIO_PORT_CONTROLLER_WITH_IRQ_TOP_MACROS_SVH
`define GPIO_PORT_CONTROLLER_WITH_IRQ_TOP_MACROS_SVH

// same-cycle implication, masked during reset
`define GPIO_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gpio check failed");

// next-cycle implication, masked during reset
`define GPIO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gpio check failed");

// implication checked through reset as well
`define GPIO_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("gpio reset check failed");

`endif

@@ src/gpio_pkg.sv @@
`timescale 1ns / 1ps

package gpio_pkg;

    localparam int PINS_PER_PORT  = 8;
    localparam int PORT_COUNT_DEF = 4;
    localparam int WORD_W         = 32;
    localparam logic [7:0] BYTE_MASK = 8'hFF;

    typedef logic [1:0]        t_mode;
    typedef logic [2:0]        t_reg_sel;
    typedef logic [1:0]        t_port_idx;
    typedef logic [7:0]        t_byte;
    typedef logic [WORD_W-1:0] t_word;

    localparam t_mode MODE_SAMPLE = 2'd0;
    localparam t_mode MODE_READ   = 2'd1;
    localparam t_mode MODE_WRITE  = 2'd2;
    localparam t_mode MODE_NONE   = 2'd3;

    localparam t_reg_sel REG_DATA   = 3'd0;
    localparam t_reg_sel REG_DIR    = 3'd1;
    localparam t_reg_sel REG_IEN    = 3'd2;
    localparam t_reg_sel REG_SENSE  = 3'd3;
    localparam t_reg_sel REG_BOTH   = 3'd4;
    localparam t_reg_sel REG_EVENT  = 3'd5;
    localparam t_reg_sel REG_CLEAR  = 3'd6;
    localparam t_reg_sel REG_STATUS = 3'd7;

    typedef struct packed {
        t_mode     mode;
        t_reg_sel  reg_select;
        t_port_idx port_index;
        t_byte     write_data;
        t_word     pad_levels;
    } t_item;

    typedef struct packed {
        t_word read_data;
        t_word pad_drive;
        t_word pad_output_enable;
        logic  irq_line;
    } t_result;

endpackage

@@ src/gpio_if.sv @@
`timescale 1ns / 1ps

interface gpio_item_if;
    logic                valid;
    logic                ready;
    gpio_pkg::t_mode     mode;
    gpio_pkg::t_reg_sel  reg_select;
    gpio_pkg::t_port_idx port_index;
    gpio_pkg::t_byte     write_data;
    gpio_pkg::t_word     pad_levels;

    modport source (output valid, mode, reg_select, port_index, write_data, pad_levels,
                    input ready);
    modport sink   (input valid, mode, reg_select, port_index, write_data, pad_levels,
                    output ready);
endinterface

interface gpio_result_if;
    logic            valid;
    logic            ready;
    gpio_pkg::t_word read_data;
    gpio_pkg::t_word pad_drive;
    gpio_pkg::t_word pad_output_enable;
    logic            irq_line;

    modport source (output valid, read_data, pad_drive, pad_output_enable, irq_line,
                    input ready);
    modport sink   (input valid, read_data, pad_drive, pad_output_enable, irq_line,
                    output ready);
endinterface

@@ src/gpio_regs.sv @@
`timescale 1ns / 1ps

module gpio_regs #(
    parameter int PORT_COUNT = gpio_pkg::PORT_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  gpio_pkg::t_item   i_item,
    output gpio_pkg::t_result o_next
);
    import gpio_pkg::*;

    localparam int PIN_COUNT = PORT_COUNT * PINS_PER_PORT;
    localparam logic [2:0] PORT_LIMIT = 3'(PORT_COUNT);

    logic [PIN_COUNT-1:0] r_out, r_dir, r_ien, r_sense, r_both, r_event, r_pend, r_last;
    logic [PIN_COUNT-1:0] n_out, n_dir, n_ien, n_sense, n_both, n_event, n_pend, n_last;

    logic [PIN_COUNT-1:0] w_pads, w_rise, w_fall, w_single, w_edge_hit, w_level_hit;
    logic [PIN_COUNT-1:0] w_lane_mask, w_lane_data, w_status;
    logic [4:0]           w_shift;
    logic                 w_present;
    t_word                w_mask32, w_data32, w_word32, w_rd;

    assign w_pads    = i_item.pad_levels[PIN_COUNT-1:0];
    assign w_shift   = {i_item.port_index, 3'b000};
    assign w_present = {1'b0, i_item.port_index} < PORT_LIMIT;
    assign w_mask32  = WORD_W'(BYTE_MASK) << w_shift;
    assign w_data32  = WORD_W'(i_item.write_data) << w_shift;
    assign w_lane_mask = w_mask32[PIN_COUNT-1:0];
    assign w_lane_data = w_data32[PIN_COUNT-1:0];
    assign w_status  = r_pend & r_ien;

    // edge detection against the previous sample, level detection against r_event
    assign w_rise      = w_pads & ~r_last;
    assign w_fall      = ~w_pads & r_last;
    assign w_single    = (r_event & w_rise) | (~r_event & w_fall);
    assign w_edge_hit  = (r_both & (w_rise | w_fall)) | (~r_both & w_single);
    assign w_level_hit = ~(w_pads ^ r_event);

    always_comb begin
        unique case (i_item.reg_select)
            REG_DATA:  w_word32 = WORD_W'((r_out & r_dir) | (r_last & ~r_dir));
            REG_DIR:   w_word32 = WORD_W'(r_dir);
            REG_IEN:   w_word32 = WORD_W'(r_ien);
            REG_SENSE: w_word32 = WORD_W'(r_sense);
            REG_BOTH:  w_word32 = WORD_W'(r_both);
            REG_EVENT: w_word32 = WORD_W'(r_event);
            default:   w_word32 = '0;
        endcase
    end

    always_comb begin
        n_out   = r_out;
        n_dir   = r_dir;
        n_ien   = r_ien;
        n_sense = r_sense;
        n_both  = r_both;
        n_event = r_event;
        n_pend  = r_pend;
        n_last  = r_last;
        w_rd    = '0;
        unique case (i_item.mode)
            MODE_SAMPLE: begin
                n_pend = ((r_pend | (w_edge_hit & ~r_sense)) & ~r_sense)
                       | (w_level_hit & r_sense);
                n_last = w_pads;
            end
            MODE_READ: begin
                if (i_item.reg_select == REG_STATUS) begin
                    w_rd = WORD_W'(w_status);
                end else if (w_present) begin
                    w_rd = WORD_W'(8'(w_word32 >> w_shift));
                end
            end
            MODE_WRITE: begin
                if (w_present) begin
                    unique case (i_item.reg_select)
                        REG_DATA:   n_out   = (r_out & ~w_lane_mask) | w_lane_data;
                        REG_DIR:    n_dir   = (r_dir & ~w_lane_mask) | w_lane_data;
                        REG_IEN:    n_ien   = (r_ien & ~w_lane_mask) | w_lane_data;
                        REG_SENSE:  n_sense = (r_sense & ~w_lane_mask) | w_lane_data;
                        REG_BOTH:   n_both  = (r_both & ~w_lane_mask) | w_lane_data;
                        REG_EVENT:  n_event = (r_event & ~w_lane_mask) | w_lane_data;
                        REG_CLEAR:  n_pend  = r_pend & ~w_lane_data;
                        REG_STATUS: n_pend  = r_pend;
                    endcase
                end
            end
            default: begin
                w_rd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out   <= '0;
            r_dir   <= '0;
            r_ien   <= '0;
            r_sense <= '0;
            r_both  <= '0;
            r_event <= '0;
            r_pend  <= '0;
            r_last  <= '0;
        end else if (i_en) begin
            r_out   <= n_out;
            r_dir   <= n_dir;
            r_ien   <= n_ien;
            r_sense <= n_sense;
            r_both  <= n_both;
            r_event <= n_event;
            r_pend  <= n_pend;
            r_last  <= n_last;
        end
    end

    // outputs reflect the state after this item
    assign o_next.read_data         = w_rd;
    assign o_next.pad_drive         = WORD_W'(n_out);
    assign o_next.pad_output_enable = WORD_W'(n_dir);
    assign o_next.irq_line          = |(n_pend & n_ien);

endmodule

@@ src/gpio_port_controller_with_irq_top.sv @@
`timescale 1ns / 1ps

// gpio group of up to four 8-bit ports with per-pin edge or level interrupts
// i_item carries one item per handshake: a pad sample, a register read, a
// register write or no operation, chosen by mode; o_result gives exactly one
// result item per input item, in order
// every result shows read_data (zero unless a read), the pad drive and
// output enable words and the irq line, all as they stand after the item
// the result is registered: valid in the cycle after its item is accepted
// throughput: one item per cycle while results are taken; the state update
// and result are combinational between the register bank and result register
// a stalled result holds in the result register; a new item is still taken
// in the cycle the result is taken, otherwise i_item.ready drops
// reset clears all port registers, pending bits, the last pad sample and
// the result valid flag; the block is ready in the first cycle after reset
module gpio_port_controller_with_irq_top #(
    parameter int PORT_COUNT = gpio_pkg::PORT_COUNT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gpio_item_if.sink     i_item,
    gpio_result_if.source o_result
);
    import gpio_pkg::*;

    logic    w_accept;
    t_item   w_item;
    t_result w_next;
    t_result r_result;
    logic    r_valid;

    assign i_item.ready = !r_valid || o_result.ready;
    assign w_accept     = i_item.valid && i_item.ready;

    assign w_item.mode       = i_item.mode;
    assign w_item.reg_select = i_item.reg_select;
    assign w_item.port_index = i_item.port_index;
    assign w_item.write_data = i_item.write_data;
    assign w_item.pad_levels = i_item.pad_levels;

    gpio_regs #(
        .PORT_COUNT(PORT_COUNT)
    ) u_regs (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_accept),
        .i_item (w_item),
        .o_next (w_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= w_next;
        end
    end

    assign o_result.valid             = r_valid;
    assign o_result.read_data         = r_result.read_data;
    assign o_result.pad_drive         = r_result.pad_drive;
    assign o_result.pad_output_enable = r_result.pad_output_enable;
    assign o_result.irq_line          = r_result.irq_line;

endmodule

@@ src/gpio_chk.sv @@
`timescale 1ns / 1ps
`include "gpio_port_controller_with_irq_top_macros.svh"

module gpio_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input gpio_pkg::t_mode     i_mode,
    input gpio_pkg::t_reg_sel  i_reg_select,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input gpio_pkg::t_word     i_read_data,
    input gpio_pkg::t_word     i_pad_drive,
    input logic                i_irq_line
);
    import gpio_pkg::*;

    // a stalled result keeps its read word, pad drive and irq line
    `GPIO_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_read_data) && $stable(i_pad_drive) && $stable(i_irq_line))

    // no result straight out of reset
    `GPIO_ASSERT_ALWAYS(a_reset_empty, i_clk, $past(!i_rst_n), !i_out_valid)

    // any item other than a read gives a zero read word
    `GPIO_ASSERT_NEXT(a_nonread_zero, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_mode != MODE_READ), i_out_valid && (i_read_data == '0))

    // port register reads return a single byte
    `GPIO_ASSERT_NEXT(a_byte_read, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_mode == MODE_READ) && (i_reg_select != REG_STATUS), i_out_valid && (i_read_data[31:8] == '0))

endmodule

bind gpio_port_controller_with_irq_top gpio_chk u_gpio_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_mode      (i_item.mode),
    .i_reg_select(i_item.reg_select),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_read_data (o_result.read_data),
    .i_pad_drive (o_result.pad_drive),
    .i_irq_line  (o_result.irq_line)
);

@@ tb/gpio_port_controller_with_irq_top_tb.sv @@
`timescale 1ns / 1ps

module gpio_port_controller_with_irq_top_tb;
    import gpio_pkg::*;

    localparam int    CYCLE_LIMIT  = 500000;
    localparam int    PIN_COUNT    = PORT_COUNT_DEF * PINS_PER_PORT;
    localparam t_word PRESENT_PINS = (PIN_COUNT >= WORD_W) ? {WORD_W{1'b1}} :
                                     t_word'((64'd1 << PIN_COUNT) - 64'd1);

    logic i_clk = 1'b0;
    logic i_rst_n;

    gpio_item_if   item_bus();
    gpio_result_if result_bus();

    gpio_port_controller_with_irq_top #(
        .PORT_COUNT(PORT_COUNT_DEF)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_bus),
        .o_result(result_bus)
    );

    // shadow copy of the port registers
    t_word gp_out_latch   = '0;
    t_word gp_direction   = '0;
    t_word gp_irq_enable  = '0;
    t_word gp_level_sense = '0;
    t_word gp_any_edge    = '0;
    t_word gp_polarity    = '0;
    t_word gp_pending     = '0;
    t_word gp_last_pads   = '0;

    t_result gpio_outcomes[$];
    int      error_count   = 0;
    int      cycle_count   = 0;
    bit      source_gaps   = 1'b1;
    bit      sink_stalls   = 1'b1;
    int      hold_request  = 0;
    t_word   pad_trend     = '0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL gpio_port_controller_with_irq_top");
            $finish;
        end
    end

    function automatic int stretch_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // updates the shadow registers for one item and returns its result
    function automatic t_result apply_gpio_item(t_item it);
        t_result r;
        t_word   pads, rise, fall, single, edge_hit, level_hit, word, lane, val;
        int      shift;
        r     = '0;
        word  = '0;
        shift = int'(it.port_index) * PINS_PER_PORT;
        pads  = it.pad_levels & PRESENT_PINS;
        lane  = t_word'(BYTE_MASK) << shift;
        val   = t_word'(it.write_data) << shift;
        if (it.mode == MODE_SAMPLE) begin
            rise      = pads & ~gp_last_pads;
            fall      = ~pads & gp_last_pads;
            single    = (gp_polarity & rise) | (~gp_polarity & fall);
            edge_hit  = (gp_any_edge & (rise | fall)) | (~gp_any_edge & single);
            level_hit = ~(pads ^ gp_polarity);
            // edge hits latch, level pins follow the pad
            gp_pending = gp_pending | (edge_hit & ~gp_level_sense);
            gp_pending = (gp_pending & ~gp_level_sense) | (level_hit & gp_level_sense);
            gp_pending = gp_pending & PRESENT_PINS;
            gp_last_pads = pads;
        end else if (it.mode == MODE_READ) begin
            if (it.reg_select == REG_STATUS) begin
                r.read_data = gp_pending & gp_irq_enable;
            end else if (int'(it.port_index) < PORT_COUNT_DEF) begin
                case (it.reg_select)
                    REG_DATA:  word = (gp_out_latch & gp_direction) |
                                      (gp_last_pads & ~gp_direction);
                    REG_DIR:   word = gp_direction;
                    REG_IEN:   word = gp_irq_enable;
                    REG_SENSE: word = gp_level_sense;
                    REG_BOTH:  word = gp_any_edge;
                    REG_EVENT: word = gp_polarity;
                    default:   word = '0;
                endcase
                r.read_data = (word >> shift) & t_word'(BYTE_MASK);
            end
        end else if (it.mode == MODE_WRITE && int'(it.port_index) < PORT_COUNT_DEF) begin
            case (it.reg_select)
                REG_DATA:  gp_out_latch   = (gp_out_latch & ~lane) | val;
                REG_DIR:   gp_direction   = (gp_direction & ~lane) | val;
                REG_IEN:   gp_irq_enable  = (gp_irq_enable & ~lane) | val;
                REG_SENSE: gp_level_sense = (gp_level_sense & ~lane) | val;
                REG_BOTH:  gp_any_edge    = (gp_any_edge & ~lane) | val;
                REG_EVENT: gp_polarity    = (gp_polarity & ~lane) | val;
                REG_CLEAR: gp_pending     = gp_pending & ~val;
                default:   ;
            endcase
        end
        r.pad_drive         = gp_out_latch;
        r.pad_output_enable = gp_direction;
        r.irq_line          = |(gp_pending & gp_irq_enable);
        return r;
    endfunction

    function automatic t_item mk_item(t_mode m, t_reg_sel s, t_port_idx p, t_byte d,
                                      t_word pads);
        t_item it;
        it.mode       = m;
        it.reg_select = s;
        it.port_index = p;
        it.write_data = d;
        it.pad_levels = pads;
        return it;
    endfunction

    function automatic t_item random_gpio_item();
        t_item it;
        int    pick;
        it.reg_select = t_reg_sel'($urandom_range(0, 7));
        it.port_index = t_port_idx'($urandom_range(0, 3));
        pick = $urandom_range(0, 9);
        it.write_data = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : t_byte'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 40)      it.mode = MODE_SAMPLE;
        else if (pick < 70) it.mode = MODE_WRITE;
        else if (pick < 97) it.mode = MODE_READ;
        else                it.mode = MODE_NONE;
        // mostly a few pins toggle per sample so edges stay sparse
        pick = $urandom_range(0, 19);
        if (pick == 0)      pad_trend = '0;
        else if (pick == 1) pad_trend = '1;
        else if (pick < 5)  pad_trend = $urandom;
        else                pad_trend = pad_trend ^ ($urandom & $urandom & $urandom);
        it.pad_levels = pad_trend;
        return it;
    endfunction

    task automatic send_item(input t_item it);
        int gap;
        gap = 0;
        if (source_gaps && $urandom_range(0, 99) < 30) gap = stretch_len();
        if (gap > 0) begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_bus.valid      <= 1'b1;
        item_bus.mode       <= it.mode;
        item_bus.reg_select <= it.reg_select;
        item_bus.port_index <= it.port_index;
        item_bus.write_data <= it.write_data;
        item_bus.pad_levels <= it.pad_levels;
        do @(posedge i_clk); while (item_bus.ready !== 1'b1);
        gpio_outcomes.push_back(apply_gpio_item(it));
    endtask

    // receiver side: random stalls plus a long hold-off on request
    initial begin : result_drain
        int   stall_left;
        logic take;
        stall_left = 0;
        result_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left == 0 && sink_stalls && $urandom_range(0, 99) < 20)
                stall_left = stretch_len();
            take = (stall_left == 0);
            if (stall_left > 0) stall_left--;
            result_bus.ready <= take;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
            if (gpio_outcomes.size() == 0) begin
                $error("result item with no expected result waiting");
                error_count++;
            end else begin
                want = gpio_outcomes.pop_front();
                if (result_bus.read_data !== want.read_data) begin
                    $error("read_data: expected %h, got %h", want.read_data,
                           result_bus.read_data);
                    error_count++;
                end
                if (result_bus.pad_drive !== want.pad_drive) begin
                    $error("pad_drive: expected %h, got %h", want.pad_drive,
                           result_bus.pad_drive);
                    error_count++;
                end
                if (result_bus.pad_output_enable !== want.pad_output_enable) begin
                    $error("pad_output_enable: expected %h, got %h",
                           want.pad_output_enable, result_bus.pad_output_enable);
                    error_count++;
                end
                if (result_bus.irq_line !== want.irq_line) begin
                    $error("irq_line: expected %b, got %b", want.irq_line,
                           result_bus.irq_line);
                    error_count++;
                end
            end
        end
    end

    task automatic test_reset_state();
        send_item(mk_item(MODE_READ, REG_STATUS, 2'd0, 8'h00, '0));
        send_item(mk_item(MODE_READ, REG_DATA, 2'd3, 8'h00, '0));
    endtask

    // input pins read back the pad, output pins the latch
    task automatic test_data_readback();
        send_item(mk_item(MODE_WRITE, REG_DATA, 2'd2, 8'hFF, '0));
        send_item(mk_item(MODE_WRITE, REG_DIR, 2'd2, 8'hF0, '0));
        send_item(mk_item(MODE_SAMPLE, REG_DATA, 2'd0, 8'h00, 32'h5A5A_5A5A));
        send_item(mk_item(MODE_READ, REG_DATA, 2'd2, 8'h00, '0));
    endtask

    task automatic test_edge_irq();
        send_item(mk_item(MODE_WRITE, REG_IEN, 2'd0, 8'hFF, '0));
        send_item(mk_item(MODE_WRITE, REG_EVENT, 2'd0, 8'h0F, '0));
        send_item(mk_item(MODE_WRITE, REG_BOTH, 2'd0, 8'h30, '0));
        send_item(mk_item(MODE_SAMPLE, REG_DATA, 2'd0, 8'h00, 32'h0000_00FF));
        send_item(mk_item(MODE_SAMPLE, REG_DATA, 2'd0, 8'h00, 32'h0000_0000));
        // status ignores the port, and writing it does nothing
        send_item(mk_item(MODE_READ, REG_STATUS, 2'd2, 8'h00, '0));
        send_item(mk_item(MODE_WRITE, REG_STATUS, 2'd0, 8'hFF, '0));
        send_item(mk_item(MODE_WRITE, REG_CLEAR, 2'd0, 8'hFF, '0));
        send_item(mk_item(MODE_READ, REG_CLEAR, 2'd0, 8'h00, '0));
        send_item(mk_item(MODE_READ, REG_STATUS, 2'd0, 8'h00, '0));
    endtask

    task automatic test_level_irq();
        // output pins are sensed as well
        send_item(mk_item(MODE_WRITE, REG_DIR, 2'd3, 8'h3C, '0));
        send_item(mk_item(MODE_WRITE, REG_SENSE, 2'd3, 8'hFF, '0));
        send_item(mk_item(MODE_WRITE, REG_EVENT, 2'd3, 8'h0F, '0));
        send_item(mk_item(MODE_WRITE, REG_IEN, 2'd3, 8'hFF, '0));
        send_item(mk_item(MODE_SAMPLE, REG_DATA, 2'd0, 8'h00, 32'h0F00_0000));
        // a clear is undone by the next sample while the pad still matches
        send_item(mk_item(MODE_WRITE, REG_CLEAR, 2'd3, 8'hFF, '0));
        send_item(mk_item(MODE_SAMPLE, REG_DATA, 2'd0, 8'h00, 32'h0F00_0000));
        // back to edge mode: pending holds until cleared
        send_item(mk_item(MODE_WRITE, REG_SENSE, 2'd3, 8'h00, '0));
        send_item(mk_item(MODE_READ, REG_STATUS, 2'd1, 8'h00, '0));
    endtask

    task automatic test_unused_mode();
        send_item(mk_item(MODE_NONE, REG_DATA, 2'd1, 8'hFF, 32'hFFFF_FFFF));
    endtask

    task automatic test_backpressure();
        source_gaps  = 1'b0;
        sink_stalls  = 1'b0;
        hold_request = 200;
        repeat (40) send_item(random_gpio_item());
        source_gaps = 1'b1;
        sink_stalls = 1'b1;
    endtask

    task automatic test_random_traffic(input int count, input bit with_gaps,
                                       input bit with_stalls);
        source_gaps = with_gaps;
        sink_stalls = with_stalls;
        repeat (count) send_item(random_gpio_item());
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        item_bus.valid      <= 1'b0;
        item_bus.mode       <= MODE_SAMPLE;
        item_bus.reg_select <= REG_DATA;
        item_bus.port_index <= '0;
        item_bus.write_data <= '0;
        item_bus.pad_levels <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_data_readback();
        test_edge_irq();
        test_level_irq();
        test_unused_mode();
        test_backpressure();
        test_random_traffic(400, 1'b0, 1'b0);
        test_random_traffic(400, 1'b1, 1'b0);
        test_random_traffic(400, 1'b0, 1'b1);
        test_random_traffic(300, 1'b1, 1'b1);

        item_bus.valid <= 1'b0;
        while (gpio_outcomes.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS gpio_port_controller_with_irq_top");
        end else begin
            $display("FAIL gpio_port_controller_with_irq_top");
        end
        $finish;
    end

endmodule
